// ===== rtl/core/battery_voltage_monitor_assert.svh =====
// Assertion macros used by the battery voltage monitor top level.
`ifndef BATTERY_VOLTAGE_MONITOR_ASSERT_SVH
`define BATTERY_VOLTAGE_MONITOR_ASSERT_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define BVM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("battery_voltage_monitor: check failed");
// The consequent must hold in the cycle after the antecedent.
`define BVM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("battery_voltage_monitor: check failed");
`else
`define BVM_ASSERT_SAME(label, ante, cons)
`define BVM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/bvm_pkg.sv =====
// Shared constants and types of the battery voltage monitor.
package bvm_pkg;

  localparam int ADC_BITS       = 12;
  localparam int MV_W           = 13;
  localparam int BURST_LEN      = 10;
  localparam int BURST_CNT_W    = $clog2(BURST_LEN);
  localparam int SUM_W          = $clog2(BURST_LEN * ((1 << ADC_BITS) - 1) + 1);
  localparam int TRIM_SHIFT     = 3;
  localparam int VREF_MV        = 2500;
  localparam int RING_INIT_MV   = 3700;
  localparam int RING_DEPTH_DEF = 8;
  localparam int RATIO_W        = 2;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 13;
  localparam int RATIO_RST      = 3;
  localparam int STANDBY_RST    = 3300;
  localparam int WARNING_RST    = 3450;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCALE_RATIO = 2'd0,
    REG_STANDBY_TH  = 2'd1,
    REG_WARNING_TH  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] raw_sample;
  } sample_word_t;

  typedef struct packed {
    logic [MV_W-1:0] burst_mv;
    logic [MV_W-1:0] average_mv;
    logic            standby_request;
    logic            low_warning;
  } result_word_t;

  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [ADC_BITS-1:0] lo;
    logic [ADC_BITS-1:0] hi;
  } burst_stats_t;

  typedef struct packed {
    logic prefetch;
    logic commit;
  } ring_ctl_t;

endpackage

// ===== rtl/core/bvm_stream_if.sv =====
// Valid/ready stream interface carrying one payload word per handshake.
interface bvm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/bvm_burst_acc.sv =====
// Burst accumulator: running sum, minimum and maximum over each burst of samples.
module bvm_burst_acc
  import bvm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [ADC_BITS-1:0] raw,
  output logic                last,
  output burst_stats_t        stats,
  output logic                stats_valid
);

  logic [BURST_CNT_W-1:0] count;
  logic [SUM_W-1:0]       sum;
  logic [ADC_BITS-1:0]    lo;
  logic [ADC_BITS-1:0]    hi;
  logic [SUM_W-1:0]       sum_next;
  logic [ADC_BITS-1:0]    lo_next;
  logic [ADC_BITS-1:0]    hi_next;

  always_comb begin
    sum_next = sum + SUM_W'(raw);
    lo_next  = (raw < lo) ? raw : lo;
    hi_next  = (raw > hi) ? raw : hi;
    last     = (count == BURST_CNT_W'(BURST_LEN - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      sum         <= '0;
      lo          <= '1;
      hi          <= '0;
      stats_valid <= 1'b0;
    end else begin
      stats_valid <= accept && last;
      if (accept) begin
        if (last) begin
          count <= '0;
          sum   <= '0;
          lo    <= '1;
          hi    <= '0;
        end else begin
          count <= count + 1'b1;
          sum   <= sum_next;
          lo    <= lo_next;
          hi    <= hi_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      stats <= '{sum: sum_next, lo: lo_next, hi: hi_next};
    end
  end

endmodule

// ===== rtl/core/bvm_ring.sv =====
// Ring of recent burst voltages with its running total.
module bvm_ring
  import bvm_pkg::*;
#(
  parameter int  RING_DEPTH = RING_DEPTH_DEF,
  localparam int POS_W      = $clog2(RING_DEPTH),
  localparam int TOT_W      = MV_W + $clog2(RING_DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  ring_ctl_t        ctl,
  input  logic [MV_W-1:0]  mv,
  output logic [TOT_W-1:0] total
);

  logic [MV_W-1:0]       mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld;
  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      nxt;
  logic [MV_W-1:0]       rd_data;
  logic                  rd_vld;
  logic [MV_W-1:0]       old_mv;

  always_comb begin
    nxt    = (pos == POS_W'(RING_DEPTH - 1)) ? '0 : pos + 1'b1;
    // An entry never written reads as the power-up voltage.
    old_mv = rd_vld ? rd_data : MV_W'(RING_INIT_MV);
  end

  always_ff @(posedge clk) begin
    if (ctl.prefetch) begin
      rd_data <= mem[nxt];
    end
    if (ctl.commit) begin
      mem[nxt] <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      pos    <= '0;
      rd_vld <= 1'b0;
      total  <= TOT_W'(RING_INIT_MV * RING_DEPTH);
    end else begin
      if (ctl.prefetch) begin
        rd_vld <= vld[nxt];
      end
      if (ctl.commit) begin
        vld[nxt] <= 1'b1;
        pos      <= nxt;
        total    <= total - TOT_W'(old_mv) + TOT_W'(mv);
      end
    end
  end

endmodule

// ===== rtl/core/battery_voltage_monitor.sv =====
// Top level of the battery voltage monitor: burst trimming, ring average, limits.
//
//  channel   dir  word                                               handshake
//  sample    in   raw_sample                                         valid/ready
//  result    out  burst_mv, average_mv, standby_request, low_warning valid/ready
//  cfg       in   cfg_index, cfg_data                                cfg_write
//
// One sample word is taken per cycle while sample.ready is high. The tenth word of a
// burst starts a four-stage pass (trim, scale multiply, ring update, average multiply)
// and its result word is then offered from the output register.
// Only one burst is in that pass at a time: a burst-ending sample waits while the
// previous burst has not reached the output register; other samples are never held.
// Reset is synchronous; the ring reads as 3700 mV per entry until each entry is written.
module battery_voltage_monitor
  import bvm_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  bvm_stream_if.sink             sample,
  bvm_stream_if.source           result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  `include "battery_voltage_monitor_assert.svh"

  localparam int TOT_W      = MV_W + $clog2(RING_DEPTH);
  localparam int DIV_SHIFT  = TOT_W + $clog2(RING_DEPTH);
  localparam int MUL_W      = TOT_W + 1;
  localparam int AVG_PROD_W = TOT_W + MUL_W;
  localparam int MV_PROD_W  = ADC_BITS + MV_W;
  // Reciprocal of the ring depth, exact for every total the ring can hold.
  localparam logic [MUL_W-1:0] DIV_MUL =
    MUL_W'(((64'd1 << DIV_SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

  logic [RATIO_W-1:0] ratio;
  logic [MV_W-1:0]    standby_th;
  logic [MV_W-1:0]    warning_th;
  logic               warned;

  logic               accept;
  logic               last;
  logic               busy;
  burst_stats_t       stats;
  logic               stats_valid;

  logic [SUM_W-1:0]      trimmed;
  logic [ADC_BITS-1:0]   mean;
  logic [MV_W-1:0]       scale;
  logic [MV_PROD_W-1:0]  mv_prod;
  logic [MV_W-1:0]       mv;
  logic [MV_W-1:0]       burst_mv;
  logic [TOT_W-1:0]      total;
  logic [AVG_PROD_W-1:0] avg_prod;
  logic [MV_W-1:0]       avg;
  logic                  standby_c;
  logic                  warn_c;
  logic                  v2;
  logic                  v3;
  logic                  v4;
  logic                  adv4;
  logic                  out_valid;
  result_word_t          out_word;
  ring_ctl_t             ring_ctl;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio      <= RATIO_W'(RATIO_RST);
      standby_th <= MV_W'(STANDBY_RST);
      warning_th <= MV_W'(WARNING_RST);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCALE_RATIO: ratio      <= cfg_data[RATIO_W-1:0];
        REG_STANDBY_TH:  standby_th <= cfg_data[MV_W-1:0];
        REG_WARNING_TH:  warning_th <= cfg_data[MV_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy         = stats_valid | v2 | v3 | v4;
  assign sample.ready = !(last && busy);
  assign accept       = sample.valid && sample.ready;

  bvm_burst_acc u_acc (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .raw         (sample.data.raw_sample),
    .last        (last),
    .stats       (stats),
    .stats_valid (stats_valid)
  );

  assign ring_ctl.prefetch = stats_valid;
  assign ring_ctl.commit   = v3;

  bvm_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ring_ctl),
    .mv    (mv),
    .total (total)
  );

  always_comb begin
    // The sum holds the extremes, so dropping them cannot go negative.
    trimmed = stats.sum - SUM_W'(stats.lo) - SUM_W'(stats.hi);
    case (ratio)
      2'd0:    scale = '0;
      2'd1:    scale = MV_W'(VREF_MV);
      2'd2:    scale = MV_W'(2 * VREF_MV);
      default: scale = MV_W'(3 * VREF_MV);
    endcase
    mv_prod   = MV_PROD_W'(mean) * MV_PROD_W'(scale);
    avg_prod  = AVG_PROD_W'(total) * AVG_PROD_W'(DIV_MUL);
    avg       = avg_prod[DIV_SHIFT+MV_W-1:DIV_SHIFT];
    standby_c = (avg < standby_th);
    warn_c    = (avg < warning_th) && !warned;
    adv4      = v4 && (!out_valid || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
      warned    <= 1'b0;
    end else begin
      v2        <= stats_valid;
      v3        <= v2;
      v4        <= v3 || (v4 && !adv4);
      out_valid <= adv4 || (out_valid && !result.ready);
      if (adv4 && warn_c) begin
        warned <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stats_valid) begin
      mean <= trimmed[ADC_BITS+TRIM_SHIFT-1:TRIM_SHIFT];
    end
    if (v2) begin
      mv <= mv_prod[MV_PROD_W-1:ADC_BITS];
    end
    if (v3) begin
      burst_mv <= mv;
    end
    if (adv4) begin
      out_word <= '{burst_mv: burst_mv, average_mv: avg,
                    standby_request: standby_c, low_warning: warn_c};
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_word;

  `BVM_ASSERT_SAME(a_one_burst_in_flight, stats_valid, !(v2 || v3 || v4))
  `BVM_ASSERT_SAME(a_stall_only_at_burst_end, !sample.ready, last && busy)
  `BVM_ASSERT_NEXT(a_warning_latches, adv4 && warn_c, warned && out_valid)

endmodule

// ===== dv/battery_voltage_monitor_tb.sv =====
// Self-checking testbench for the battery voltage monitor: burst trimming, ring average, limits.
`timescale 1ns / 100ps

module battery_voltage_monitor_tb;
  import bvm_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASES        = 6;
  localparam int BURSTS        = 25;
  localparam int POS_W         = $clog2(RING_DEPTH_DEF);

  class reading_scoreboard;
    logic [RATIO_W-1:0]  ratio;
    logic [MV_W-1:0]     standby_mv;
    logic [MV_W-1:0]     warning_mv;
    logic [3:0]          count;
    logic [15:0]         sum;
    logic [ADC_BITS-1:0] lo;
    logic [ADC_BITS-1:0] hi;
    logic [MV_W-1:0]     history [RING_DEPTH_DEF];
    logic [POS_W-1:0]    pos;
    logic [15:0]         total;
    bit                  warned;
    result_word_t        pending_readings [$];
    int                  errors;

    function new();
      ratio      = RATIO_W'(RATIO_RST);
      standby_mv = MV_W'(STANDBY_RST);
      warning_mv = MV_W'(WARNING_RST);
      clear_burst();
      foreach (history[i]) history[i] = MV_W'(RING_INIT_MV);
      pos    = '0;
      total  = 16'(RING_INIT_MV * RING_DEPTH_DEF);
      warned = 1'b0;
      errors = 0;
    endfunction

    function void clear_burst();
      count = '0;
      sum   = '0;
      lo    = '1;
      hi    = '0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_SCALE_RATIO: ratio = value[RATIO_W-1:0];
        REG_STANDBY_TH:  standby_mv = value[MV_W-1:0];
        REG_WARNING_TH:  warning_mv = value[MV_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction

    // Only the tenth word of a burst yields a reading.
    function void note_sample(sample_word_t word);
      int unsigned  mean;
      int unsigned  mv;
      int unsigned  avg;
      result_word_t reading;
      sum = sum + word.raw_sample;
      if (word.raw_sample < lo) lo = word.raw_sample;
      if (word.raw_sample > hi) hi = word.raw_sample;
      count = count + 1'b1;
      if (count < BURST_LEN) return;
      mean = (sum - lo - hi) >> TRIM_SHIFT;
      mv   = ((mean * VREF_MV * ratio) >> ADC_BITS) & ((1 << MV_W) - 1);
      clear_burst();
      pos = pos + 1'b1;
      total = 16'(total - history[pos] + mv);
      history[pos] = MV_W'(mv);
      avg = (total / RING_DEPTH_DEF) & ((1 << MV_W) - 1);
      reading.burst_mv        = MV_W'(mv);
      reading.average_mv      = MV_W'(avg);
      reading.standby_request = (avg < standby_mv);
      reading.low_warning     = (avg < warning_mv) && !warned;
      if (reading.low_warning) warned = 1'b1;
      pending_readings.push_back(reading);
    endfunction

    task report(string what, int unsigned want, int unsigned got);
      errors++;
      $display("mismatch: %s expected %0d got %0d", what, want, got);
    endtask

    task check_reading(result_word_t got);
      result_word_t want;
      if (pending_readings.size() == 0) begin
        report("reading with none pending", 0, 1);
        return;
      end
      want = pending_readings.pop_front();
      if (got.burst_mv !== want.burst_mv) report("burst_mv", want.burst_mv, got.burst_mv);
      if (got.average_mv !== want.average_mv)
        report("average_mv", want.average_mv, got.average_mv);
      if (got.standby_request !== want.standby_request)
        report("standby_request", want.standby_request, got.standby_request);
      if (got.low_warning !== want.low_warning)
        report("low_warning", want.low_warning, got.low_warning);
    endtask

    task check_drained();
      if (pending_readings.size() != 0)
        report("readings never delivered", 0, pending_readings.size());
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  cfg_reg_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;

  reading_scoreboard readings = new();

  bvm_stream_if #(.payload_t(sample_word_t)) sample_ch ();
  bvm_stream_if #(.payload_t(result_word_t)) result_ch ();

  battery_voltage_monitor DUT (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) readings.check_reading(result_ch.data);
      if (sample_ch.valid && sample_ch.ready) readings.note_sample(sample_ch.data);
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_sample(input logic [ADC_BITS-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data  <= sample_word_t'(value);
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  // The first edge lets the last accepted word reach the scoreboard before it is polled.
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (readings.pending() != 0) @(posedge clk);
  endtask

  task automatic write_settings(input logic [RATIO_W-1:0] ratio,
                                input logic [MV_W-1:0] standby_mv,
                                input logic [MV_W-1:0] warning_mv);
    cfg_write <= 1'b1;
    cfg_index <= REG_SCALE_RATIO;
    cfg_data  <= CFG_DATA_W'(ratio);
    @(posedge clk);
    readings.set_reg(REG_SCALE_RATIO, CFG_DATA_W'(ratio));
    cfg_index <= REG_STANDBY_TH;
    cfg_data  <= standby_mv;
    @(posedge clk);
    readings.set_reg(REG_STANDBY_TH, standby_mv);
    cfg_index <= REG_WARNING_TH;
    cfg_data  <= warning_mv;
    @(posedge clk);
    readings.set_reg(REG_WARNING_TH, warning_mv);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [ADC_BITS-1:0] pick_sample(int style, int level);
    int v;
    case (style)
      0: begin
        v = level + $urandom_range(160) - 80;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return ADC_BITS'(v);
      end
      1: return ADC_BITS'($urandom_range(4095));
      default: return $urandom_range(1) ? 12'hFFF : 12'h000;
    endcase
  endfunction

  initial begin
    logic [ADC_BITS-1:0] mixed_burst [10];
    logic [RATIO_W-1:0] ratio;
    logic [MV_W-1:0]    standby_mv;
    logic [MV_W-1:0]    warning_mv;
    int level;
    int style;
    int pause_burst;
    int pause_word;
    int pick;

    mixed_burst = '{12'hFFF, 12'h000, 12'hAAA, 12'h555, 12'hFFF,
                    12'h000, 12'h800, 12'h7FF, 12'h001, 12'hFFE};
    sample_ch.valid <= 1'b0;
    sample_ch.data  <= '0;
    cfg_write       <= 1'b0;
    cfg_index       <= REG_SCALE_RATIO;
    cfg_data        <= '0;
    rst             <= 1'b1;
    send_idle_pct = 35;
    recv_idle_pct = 75;
    level = 2048;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed bursts at reset settings: min and max at the code extremes, then an
    // all-zero burst that pulls the average under both limits, then a full-scale burst.
    foreach (mixed_burst[i]) send_sample(mixed_burst[i]);
    repeat (10) send_sample(12'h000);
    repeat (10) send_sample(12'hFFF);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (ph / 2)
        0: begin send_idle_pct = 35; recv_idle_pct = 75; end
        1: begin send_idle_pct = 75; recv_idle_pct = 35; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (ph)
        0: begin ratio = 2'd1; standby_mv = '0;  warning_mv = '0;  end
        1: begin ratio = 2'd2; standby_mv = '1;  warning_mv = '1;  end
        2: begin ratio = 2'd0; standby_mv = 1000; warning_mv = 2000; end
        3: begin ratio = 2'd3; standby_mv = 3300; warning_mv = 3450; end
        4: begin
          ratio      = 2'd3;
          standby_mv = MV_W'($urandom_range(6000, 2000));
          warning_mv = MV_W'($urandom_range(8191));
        end
        default: begin ratio = 2'd1; standby_mv = 1200; warning_mv = 1500; end
      endcase
      write_settings(ratio, standby_mv, warning_mv);
      pause_burst = $urandom_range(BURSTS - 1);
      pause_word  = $urandom_range(9);
      for (int b = 0; b < BURSTS; b++) begin
        // A slow random walk of the level lets the ring average cross the limits.
        level = level + $urandom_range(800) - 400;
        if (level < 0) level = 0;
        if (level > 4095) level = 4095;
        pick  = $urandom_range(9);
        style = (pick < 5) ? 0 : (pick < 8) ? 1 : 2;
        for (int k = 0; k < 10; k++) begin
          if (b == pause_burst && k == pause_word) wait_drained();
          send_sample(pick_sample(style, level));
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    readings.check_drained();
    if (readings.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bvm_pkg.sv
rtl/core/bvm_stream_if.sv
rtl/core/bvm_burst_acc.sv
rtl/core/bvm_ring.sv
rtl/core/battery_voltage_monitor.sv
dv/battery_voltage_monitor_tb.sv
